@@ sv/smp_pkg.sv @@
// Package for the stepwise mutation probability block.
// Word types, fixed-point constants, register indexes and the exp table.
package smp_pkg;

  localparam int unsigned MaxLoci     = 32;
  localparam int unsigned ParamRows   = 6;
  localparam logic [16:0] OneQ16      = 17'h10000;
  localparam int unsigned TaylorTerms = 12;
  localparam int unsigned QuoBits     = 17;
  // range split, series set-up, two stages a term, divide set-up, divide, output
  localparam int unsigned LogLat      = 1 + 1 + 2 * TaylorTerms + 1 + QuoBits + 1;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MODEL_STEP = 2'd0,
    MODEL_LOG  = 2'd1,
    MODEL_TWO  = 2'd2,
    MODEL_RSVD = 2'd3
  } model_e;

  typedef enum logic [0:0] {
    REG_MODEL = 1'b0,
    REG_LOCI  = 1'b1
  } reg_e;

  typedef struct packed {
    logic               operation;
    logic [4:0]         locus;
    logic [2:0]         param_row;
    logic signed [31:0] param_value;
    logic [7:0]         allele;
  } in_word_t;

  typedef struct packed {
    logic [16:0] prob_down;
    logic [16:0] prob_up;
    logic [16:0] prob_stay;
    logic        stay_clamped;
    logic        locus_error;
  } out_word_t;

  // exp(-k) in Q1.30, k = 0..15
  function automatic logic [30:0] exp_neg_q30(input logic [3:0] k);
    unique case (k)
      4'd0:  return 31'd1073741824;
      4'd1:  return 31'd395007542;
      4'd2:  return 31'd145315153;
      4'd3:  return 31'd53458458;
      4'd4:  return 31'd19666267;
      4'd5:  return 31'd7234815;
      4'd6:  return 31'd2661540;
      4'd7:  return 31'd979126;
      4'd8:  return 31'd360200;
      4'd9:  return 31'd132510;
      4'd10: return 31'd48748;
      4'd11: return 31'd17933;
      4'd12: return 31'd6597;
      4'd13: return 31'd2427;
      4'd14: return 31'd893;
      default: return 31'd328;
    endcase
  endfunction

  // Clamp a signed Q.16 value to [0,1]
  function automatic logic [16:0] sat_q16(input logic signed [32:0] v);
    if (v < 0) return 17'd0;
    if (v > 33'sd65536) return OneQ16;
    return v[16:0];
  endfunction

  // Q.32 product to Q1.16, rounding half up, saturating
  function automatic logic [16:0] sat_q32(input logic signed [64:0] p);
    logic [64:0] r;
    r = 65'(p) + 65'd32768;
    if (p <= 0) return 17'd0;
    r = r >> 16;
    if (r > 65'd65536) return OneQ16;
    return r[16:0];
  endfunction

  // Q.32 to Q.16, truncating toward zero
  function automatic logic signed [48:0] q32_to_q16(input logic signed [64:0] p);
    logic [64:0] m;
    m = p[64] ? 65'(-p) : 65'(p);
    m = m >> 16;
    return p[64] ? -$signed(m[48:0]) : $signed(m[48:0]);
  endfunction

endpackage

@@ sv/smp_logistic.sv @@
// Pipelined logistic unit L(x) = 1/(1+exp(x)), x signed Q.16, result Q.16.
// Uses smp_pkg for the exp(-k) table. The whole pipe holds while en_i is low.
module smp_logistic
  import smp_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [48:0] x_i,
  output logic [16:0]        l_o
);

  // Stage 0: magnitude, saturation flag, sign
  logic        neg_q, sat_q;
  logic [3:0]  k_q;
  logic [15:0] f_q;
  logic [63:0] mag;

  assign mag = x_i[48] ? 64'(-x_i) : 64'(x_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= x_i[48];
      sat_q <= (mag >= 64'(32'd16 << 16));
      k_q   <= mag[19:16];
      f_q   <= mag[15:0];
    end
  end

  // Taylor series, one term in two stages: term*x>>30, then divide by n
  logic [30:0] term_q [TaylorTerms+1];
  logic [32:0] sum_q  [TaylorTerms+1];
  logic [29:0] x_q    [TaylorTerms+1];
  logic [30:0] ek_q   [TaylorTerms+1];
  logic        neg_p  [TaylorTerms+1];
  logic        sat_p  [TaylorTerms+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q[0] <= 31'd1 << 30;
      sum_q[0]  <= 33'd1 << 30;
      x_q[0]    <= {f_q, 14'd0};
      ek_q[0]   <= exp_neg_q30(k_q);
      neg_p[0]  <= neg_q;
      sat_p[0]  <= sat_q;
    end
  end

  for (genvar n = 1; n <= TaylorTerms; n++) begin : g_term
    // exact floor division of a 30-bit value by n through a reciprocal
    localparam int unsigned Sh    = 30 + $clog2(n);
    localparam logic [30:0] Recip = 31'(((64'd1 << Sh) + 64'(n) - 64'd1) / 64'(n));
    logic [59:0] mul_w;
    logic [63:0] rmul_w;
    logic [30:0] t_w;
    logic [29:0] prod_q;
    logic [32:0] sum_a_q;
    logic [29:0] x_a_q;
    logic [30:0] ek_a_q;
    logic        neg_a_q, sat_a_q;
    assign mul_w  = 60'(term_q[n-1]) * 60'(x_q[n-1]);
    assign rmul_w = 64'(prod_q) * 64'(Recip);
    assign t_w    = 31'(rmul_w >> Sh);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q    <= mul_w[59:30];
        sum_a_q   <= sum_q[n-1];
        x_a_q     <= x_q[n-1];
        ek_a_q    <= ek_q[n-1];
        neg_a_q   <= neg_p[n-1];
        sat_a_q   <= sat_p[n-1];
        term_q[n] <= t_w;
        sum_q[n]  <= sum_a_q + 33'(t_w);
        x_q[n]    <= x_a_q;
        ek_q[n]   <= ek_a_q;
        neg_p[n]  <= neg_a_q;
        sat_p[n]  <= sat_a_q;
      end
    end
  end

  // Restoring divide (ek*2^16 + d/2)/d, quotient <= 2^16, one bit a stage
  logic [47:0] rem_q [QuoBits+1];
  logic [32:0] den_q [QuoBits+1];
  logic [16:0] quo_q [QuoBits+1];
  logic        negd  [QuoBits+1];
  logic        satd  [QuoBits+1];

  logic [32:0] d_w;
  assign d_w = 33'(ek_q[TaylorTerms]) + sum_q[TaylorTerms];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= (48'(ek_q[TaylorTerms]) << 16) + 48'(d_w >> 1);
      den_q[0] <= d_w;
      quo_q[0] <= 17'd0;
      negd[0]  <= neg_p[TaylorTerms];
      satd[0]  <= sat_p[TaylorTerms];
    end
  end

  for (genvar b = 0; b < QuoBits; b++) begin : g_div
    localparam int unsigned Bit = QuoBits - 1 - b;
    logic [48:0] shd_w;
    logic        ge_w;
    assign shd_w = 49'(den_q[b]) << Bit;
    assign ge_w  = 49'(rem_q[b]) >= shd_w;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[b+1] <= ge_w ? 48'(49'(rem_q[b]) - shd_w) : rem_q[b];
        quo_q[b+1] <= {quo_q[b][15:0], ge_w};
        den_q[b+1] <= den_q[b];
        negd[b+1]  <= negd[b];
        satd[b+1]  <= satd[b];
      end
    end
  end

  logic [16:0] pos;
  assign pos = satd[QuoBits] ? 17'd0 : quo_q[QuoBits];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_o <= negd[QuoBits] ? (OneQ16 - pos) : pos;
    end
  end

endmodule

@@ sv/str_mutation_probabilities.sv @@
// Top level of the stepwise mutation probability block.
// Uses smp_pkg and smp_logistic; parameter table in an on-chip memory.
//
// Usage: in_word_i carries load words (write one parameter) and query
// words (locus, allele). Each query gives one out_word_o; loads give none.
// Configuration: cfg_we_i writes model_select (index 0) or loci_in_use
// (index 1); the user must write only while the block is idle, the block does not enforce it.
// Throughput: one word a cycle while out_stall_i does not hold the pipe.
// A query's result passes, after the table read at the accepting edge,
// through the argument products, the logistic unit (range split, series
// set-up, two stages per Taylor term for 12 terms, divide set-up, 17 divide
// stages, output) and the output register.
// When a result waits under out_stall_i the whole pipe holds and
// in_stall_o rises with it, so no word is lost. Reset clears valid bits
// and registers to model 0, 32 loci; the table holds nothing defined
// until loaded.
// Table writes and reads overlap only between a load and a later query;
// a query reads the table in its first stage after every earlier load
// has written, so no forwarding is needed.
module str_mutation_probabilities
  import smp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o,
  input  logic      cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [5:0] cfg_data_i
);

  logic [1:0] model_q;
  logic [5:0] loci_q;
  logic       en;
  assign en         = !out_stall_i || !out_valid_o;
  assign in_stall_o = !en;

  logic acc;
  assign acc = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q <= MODEL_STEP;
      loci_q  <= 6'd32;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_MODEL: model_q <= cfg_data_i[1:0];
        REG_LOCI:  loci_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Six banks, one per row, so a query reads a whole locus at once
  logic [31:0] tab_mem [ParamRows][MaxLoci];
  logic [31:0] rd_q [ParamRows];

  always_ff @(posedge clk_i) begin
    if (acc && in_word_i.operation == OP_LOAD && 32'(in_word_i.param_row) < ParamRows)
      tab_mem[in_word_i.param_row][in_word_i.locus] <= in_word_i.param_value;
  end
  for (genvar r = 0; r < ParamRows; r++) begin : g_rd
    always_ff @(posedge clk_i) begin
      if (en) rd_q[r] <= tab_mem[r][in_word_i.locus];
    end
  end

  // Stage 1: table data valid
  logic       v1_q, err1_q;
  logic [1:0] m1_q;
  logic [7:0] al1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= acc && in_word_i.operation == OP_QUERY;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      err1_q <= {1'b0, in_word_i.locus} >= ((loci_q < 6'd32) ? loci_q : 6'd32);
      m1_q   <= model_q;
      al1_q  <= in_word_i.allele;
    end
  end

  // Stage 2: products forming logistic arguments
  logic signed [32:0] p0, p1, p2, p3, p4, p5;
  assign p0 = $signed({rd_q[0][31], rd_q[0]});
  assign p1 = $signed({rd_q[1][31], rd_q[1]});
  assign p2 = $signed({rd_q[2][31], rd_q[2]});
  assign p3 = $signed({rd_q[3][31], rd_q[3]});
  assign p4 = $signed({rd_q[4][31], rd_q[4]});
  assign p5 = $signed({rd_q[5][31], rd_q[5]});
  logic signed [33:0] ai;
  assign ai = $signed({10'b0, al1_q, 16'd0});

  logic signed [48:0] xd_q, xu_q;
  logic signed [32:0] g0_q, g1_q;
  logic               v2_q, err2_q;
  logic [1:0]         m2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      err2_q <= err1_q;
      m2_q   <= m1_q;
      if (m1_q == MODEL_TWO) begin
        xd_q <= 49'(p0 + p1 * $signed({1'b0, al1_q}));
        xu_q <= 49'(p2 + p3 * $signed({1'b0, al1_q}));
        g0_q <= p0;
        g1_q <= p3;
      end else begin
        xd_q <= q32_to_q16(65'(p1 * (p2 - ai)));
        xu_q <= q32_to_q16(65'(p4 * (p5 - ai)));
        g0_q <= p0;
        // stepwise takes the up rate from row 1
        g1_q <= (m1_q == MODEL_LOG) ? p3 : p1;
      end
    end
  end

  logic [16:0] ld, lu;
  smp_logistic u_ld (.clk_i, .en_i(en), .x_i(xd_q), .l_o(ld));
  smp_logistic u_lu (.clk_i, .en_i(en), .x_i(xu_q), .l_o(lu));

  // Delay sideband alongside the logistic units
  localparam int unsigned Dly = LogLat;
  logic               vd_q  [Dly];
  logic               ed_q  [Dly];
  logic [1:0]         md_q  [Dly];
  logic signed [32:0] gd_q  [Dly];
  logic signed [32:0] gu_q  [Dly];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < Dly; j++) vd_q[j] <= 1'b0;
    end else if (en) begin
      vd_q[0] <= v2_q;
      for (int j = 1; j < Dly; j++) vd_q[j] <= vd_q[j-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ed_q[0] <= err2_q; md_q[0] <= m2_q; gd_q[0] <= g0_q; gu_q[0] <= g1_q;
      for (int j = 1; j < Dly; j++) begin
        ed_q[j] <= ed_q[j-1]; md_q[j] <= md_q[j-1];
        gd_q[j] <= gd_q[j-1]; gu_q[j] <= gu_q[j-1];
      end
    end
  end

  // Final products, or the clamped rates for the stepwise and reserved models
  logic [16:0] dn, upv;
  logic signed [17:0] ldv, luv;
  assign ldv = $signed({1'b0, ld});
  assign luv = $signed({1'b0, lu});
  always_comb begin
    unique case (model_e'(md_q[Dly-1]))
      MODEL_LOG: begin
        dn  = sat_q32(65'(gd_q[Dly-1] * ldv));
        upv = sat_q32(65'(gu_q[Dly-1] * luv));
      end
      MODEL_TWO: begin
        dn  = sat_q32(65'($signed({1'b0, 34'(ld) * 34'(lu)})));
        upv = sat_q32(65'($signed({1'b0, 34'(ld) * 34'(OneQ16 - lu)})));
      end
      default: begin
        dn  = sat_q16(gd_q[Dly-1]);
        upv = sat_q16(gu_q[Dly-1]);
      end
    endcase
  end

  logic signed [18:0] s;
  assign s = 19'sd65536 - $signed({2'b0, dn}) - $signed({2'b0, upv});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (en) out_valid_o <= vd_q[Dly-1];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ed_q[Dly-1]) begin
        out_word_o <= '{17'd0, 17'd0, 17'd0, 1'b0, 1'b1};
      end else begin
        out_word_o <= '{dn, upv, s[18] ? 17'd0 : s[16:0], s[18], 1'b0};
      end
    end
  end

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.locus_error |-> out_word_o.prob_down == 17'd0)
    else $error("locus error with nonzero probability");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.stay_clamped |-> out_word_o.prob_stay == 17'd0)
    else $error("clamped stay not zero");

endmodule

@@ tb/str_mutation_probabilities_tb.sv @@
// Testbench for str_mutation_probabilities: a bit-true predictor, a queue of
// expected probability words and a checker. Depends on smp_pkg and the block.
module str_mutation_probabilities_tb;
  import smp_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  logic      cfg_we;
  logic [0:0] cfg_index;
  logic [5:0] cfg_data;

  str_mutation_probabilities dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  localparam int PipeSettle = 80;

  // exp(-k) in Q1.30
  localparam longint ExpNeg [16] = '{
    1073741824, 395007542, 145315153, 53458458,
    19666267, 7234815, 2661540, 979126,
    360200, 132510, 48748, 17933,
    6597, 2427, 893, 328
  };

  // Predictor state
  logic [31:0] rate_table [MaxLoci*ParamRows];
  int unsigned sel_model;
  int unsigned sel_loci;

  out_word_t prob_queue [$];
  int        mismatches;
  int        send_idle_pct;
  int        stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= (rst_n && $urandom_range(0, 99) < stall_pct);
  end

  function automatic longint exp_frac(longint f);
    longint x, term, sum;
    x = f << 14;
    term = 64'sd1 << 30;
    sum = term;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x) >>> 30) / n;
      sum += term;
    end
    return sum;
  endfunction

  function automatic longint logistic_pos(longint m);
    longint ek, d;
    if (m >= (64'sd16 << 16)) return 0;
    ek = ExpNeg[(m >>> 16) & 15];
    d = ek + exp_frac(m & 16'hFFFF);
    return (ek * 65536 + d / 2) / d;
  endfunction

  function automatic longint logistic(longint x);
    if (x < 0) return 65536 - logistic_pos(-x);
    return logistic_pos(x);
  endfunction

  function automatic longint trunc_q16(longint p);
    if (p < 0) return -((-p) >>> 16);
    return p >>> 16;
  endfunction

  function automatic longint round_prob(longint p);
    longint r;
    if (p <= 0) return 0;
    r = (p + 32768) >>> 16;
    return (r > 65536) ? 65536 : r;
  endfunction

  function automatic longint clip_prob(longint v);
    if (v < 0) return 0;
    if (v > 65536) return 65536;
    return v;
  endfunction

  function automatic longint rate_at(int unsigned loc, int unsigned row);
    return longint'($signed(rate_table[loc*ParamRows + row]));
  endfunction

  function automatic longint logistic_rate(int unsigned loc, int unsigned base, longint i);
    longint x;
    x = trunc_q16(rate_at(loc, base + 1) * (rate_at(loc, base + 2) - i * 65536));
    return round_prob(rate_at(loc, base) * logistic(x));
  endfunction

  function automatic out_word_t predict_probs(in_word_t w);
    out_word_t r;
    longint down, up, s, i, la, lb;
    int unsigned limit;
    r = '0;
    down = 0;
    up = 0;
    i = longint'(w.allele);
    limit = (sel_loci < MaxLoci) ? sel_loci : MaxLoci;
    if (w.locus >= limit) begin
      r.locus_error = 1'b1;
      return r;
    end
    case (sel_model)
      MODEL_LOG: begin
        down = logistic_rate(w.locus, 0, i);
        up = logistic_rate(w.locus, 3, i);
      end
      MODEL_TWO: begin
        la = logistic(rate_at(w.locus, 0) + rate_at(w.locus, 1) * i);
        lb = logistic(rate_at(w.locus, 2) + rate_at(w.locus, 3) * i);
        down = round_prob(la * lb);
        up = round_prob(la * (65536 - lb));
      end
      default: begin
        down = clip_prob(rate_at(w.locus, 0));
        up = clip_prob(rate_at(w.locus, 1));
      end
    endcase
    s = 65536 - down - up;
    r.prob_down = down[16:0];
    r.prob_up = up[16:0];
    if (s < 0) r.stay_clamped = 1'b1;
    else r.prob_stay = s[16:0];
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (prob_queue.size() == 0) begin
        $display("%0t unexpected word expected none actual %h", $time, out_word);
        mismatches++;
      end else begin
        e = prob_queue.pop_front();
        check_field("prob_down", e.prob_down, out_word.prob_down);
        check_field("prob_up", e.prob_up, out_word.prob_up);
        check_field("prob_stay", e.prob_stay, out_word.prob_stay);
        check_field("stay_clamped", e.stay_clamped, out_word.stay_clamped);
        check_field("locus_error", e.locus_error, out_word.locus_error);
      end
    end
  end

  // Drive one word, hold it until taken, then update the predictor
  task automatic send_word(in_word_t w);
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w.operation == OP_LOAD) begin
      if (w.locus < MaxLoci && w.param_row < ParamRows)
        rate_table[w.locus*ParamRows + w.param_row] = w.param_value;
    end else begin
      prob_queue.push_back(predict_probs(w));
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (prob_queue.size() != 0) @(posedge clk);
    repeat (PipeSettle) @(posedge clk);
  endtask

  task automatic write_reg(reg_e idx, logic [5:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODEL) sel_model = val & 3;
    else sel_loci = val;
  endtask

  task automatic load(int loc, int row, logic [31:0] val);
    in_word_t w;
    w = '0;
    w.operation = OP_LOAD;
    w.locus = 5'(loc);
    w.param_row = 3'(row);
    w.param_value = val;
    w.allele = 8'($urandom());
    send_word(w);
  endtask

  task automatic query(int loc, int allele);
    in_word_t w;
    w.operation = OP_QUERY;
    w.locus = 5'(loc);
    w.allele = 8'(allele);
    w.param_row = 3'($urandom());
    w.param_value = $urandom();
    send_word(w);
  endtask

  // Mostly plausible rates, sometimes any 32-bit word
  function automatic logic [31:0] rand_param();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 80000);
      2: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      3: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return $urandom_range(0, 255) << 16;
    endcase
  endfunction

  task automatic test_fill_table();
    send_idle_pct = 0;
    stall_pct = 0;
    for (int l = 0; l < MaxLoci; l++)
      for (int r = 0; r < ParamRows; r++) load(l, r, rand_param());
  endtask

  task automatic test_directed();
    // saturating rates and a clamped no-change
    load(0, 0, 32'h7FFF_FFFF);
    load(0, 1, 32'h8000_0000);
    load(1, 0, 32'd40000);
    load(1, 1, 32'd40000);
    load(1, 6, 32'hFFFF_FFFF);  // dropped
    load(1, 7, 32'h0000_0000);  // dropped
    query(0, 0);
    query(1, 255);
    load(2, 0, 32'd65536);
    load(2, 1, 32'd0);
    load(2, 2, 32'd0);
    load(2, 3, 32'd65536);
    load(2, 4, 32'hFFFF_0000);
    load(2, 5, 32'h00FF_0000);
    query(2, 0);
    write_reg(REG_MODEL, MODEL_LOG);
    query(2, 0);
    query(2, 255);
    query(31, 128);
    write_reg(REG_MODEL, MODEL_TWO);
    query(2, 0);
    query(2, 255);
    write_reg(REG_MODEL, MODEL_RSVD);
    query(0, 255);
    write_reg(REG_LOCI, 6'd1);
    query(0, 7);
    query(1, 7);
    query(31, 7);
    write_reg(REG_LOCI, 6'd63);
    query(31, 200);
  endtask

  task automatic random_mix(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 15) begin
        r = $urandom_range(0, 7);
        load($urandom_range(0, 31), r, rand_param());
      end else begin
        query($urandom_range(0, 31), $urandom_range(0, 255));
      end
    end
  endtask

  task automatic test_stepwise();
    write_reg(REG_MODEL, MODEL_STEP);
    write_reg(REG_LOCI, 6'd32);
    send_idle_pct = 79;
    stall_pct = 0;
    random_mix(150);
  endtask

  task automatic test_logistic();
    write_reg(REG_MODEL, MODEL_LOG);
    write_reg(REG_LOCI, 6'd20);
    send_idle_pct = 0;
    stall_pct = 79;
    random_mix(100);
    // hold off until every expected word is in, then carry on
    drain();
    random_mix(100);
  endtask

  task automatic test_two_logistic();
    write_reg(REG_MODEL, MODEL_TWO);
    write_reg(REG_LOCI, 6'd32);
    send_idle_pct = 20;
    stall_pct = 20;
    random_mix(100);
  endtask

  task automatic test_loci_limit();
    write_reg(REG_MODEL, MODEL_STEP);
    write_reg(REG_LOCI, 6'd1);
    send_idle_pct = 0;
    stall_pct = 0;
    random_mix(50);
    write_reg(REG_MODEL, MODEL_LOG);
    write_reg(REG_LOCI, 6'd63);
    random_mix(50);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MODEL;
    cfg_data = '0;
    mismatches = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    sel_model = MODEL_STEP;
    sel_loci = 32;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_table();
    test_directed();
    test_stepwise();
    test_logistic();
    test_two_logistic();
    test_loci_limit();
    drain();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
